>>> rtl/kci_pkg.sv
`timescale 1ns / 1ps
package kci_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TW = FRAC_BITS + 1;
  localparam int EW = FRAC_BITS + 3;
  localparam int NW = 26;
  localparam int RW = 26;
  localparam int DW = 25;
  localparam int VW = 35;
  localparam int PW = VW + EW;
  localparam int NPTS = 6;
  localparam int NLVL = 5;
  localparam int CUP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int CDN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  localparam logic [2:0] CURVE_INSTANT   = 3'd0;
  localparam logic [2:0] CURVE_LINEAR    = 3'd1;
  localparam logic [2:0] CURVE_QUADRATIC = 3'd2;
  localparam logic [2:0] CURVE_QUINTIC   = 3'd5;

  localparam logic [2:0] REG_CURVE    = 3'd0;
  localparam logic [2:0] REG_SPIN     = 3'd1;
  localparam logic [2:0] REG_KEY      = 3'd2;
  localparam logic [2:0] REG_NEXT_KEY = 3'd3;
  localparam logic [2:0] REG_CTRL1    = 3'd4;
  localparam logic [2:0] REG_CTRL2    = 3'd5;
  localparam logic [2:0] REG_CTRL3    = 3'd6;
  localparam logic [2:0] REG_CTRL4    = 3'd7;

  localparam logic [1:0] MODE_DIV  = 2'd0;
  localparam logic [1:0] MODE_ZERO = 2'd1;
  localparam logic [1:0] MODE_ONE  = 2'd2;

  localparam logic [TW-1:0] T_ONE = TW'(1) << FRAC_BITS;
  localparam logic signed [VW-1:0] ANGLE_TURN = VW'(360 * 65536);

  typedef struct packed {
    logic signed [31:0] sv;
    logic signed [31:0] ev;
    logic               angle;
    logic               flag;
  } side_t;

  typedef struct packed {
    side_t           side;
    logic [1:0]      mode;
    logic [RW-1:0]   rem;
    logic [DW-1:0]   den;
    logic [TW-1:0]   q;
  } div_t;

  typedef struct packed {
    side_t         side;
    logic [TW-1:0] t;
  } prog_t;

  typedef struct packed {
    side_t                        side;
    logic [TW-1:0]                t;
    logic [NPTS-1:0][EW-1:0]      p;
  } bez_t;

  function automatic logic [EW-1:0] ctrl_fix(input logic signed [17:0] c);
    logic signed [EW+7:0] w;
    w = (EW+8)'(c);
    w = (w <<< CUP) >>> CDN;
    return w[EW-1:0];
  endfunction

  function automatic logic [EW-1:0] bez_lerp(input logic signed [EW-1:0] a,
                                             input logic signed [EW-1:0] b,
                                             input logic [TW-1:0] t);
    logic signed [EW:0]        diff;
    logic signed [EW+TW+1:0]   prod;
    logic signed [EW+TW+1:0]   res;
    diff = (EW+1)'(b) - (EW+1)'(a);
    prod = (EW+TW+2)'(diff) * (EW+TW+2)'($signed({1'b0, t}));
    res  = (EW+TW+2)'(a) + (prod >>> FRAC_BITS);
    return res[EW-1:0];
  endfunction

endpackage

>>> rtl/kci_front.sv
`timescale 1ns / 1ps
module kci_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [23:0]          current_time_i,
  input  logic signed [31:0]   start_value_i,
  input  logic signed [31:0]   end_value_i,
  input  logic                 is_angle_i,
  input  logic [15:0]          key_time_i,
  input  logic [15:0]          next_key_time_i,
  output logic                 valid_o,
  output kci_pkg::div_t        data_o
);

  logic signed [kci_pkg::NW-1:0] num, num_f;
  logic signed [kci_pkg::DW:0]   den, den_f;
  kci_pkg::div_t                 data_d, data_q;
  logic                          valid_q;

  always_comb begin
    num = $signed({2'b00, current_time_i}) - $signed({2'b00, key_time_i, 8'h00});
    den = $signed({2'b00, next_key_time_i, 8'h00}) - $signed({2'b00, key_time_i, 8'h00});
    num_f = num;
    den_f = den;
    if (den < 0) begin
      num_f = -num;
      den_f = -den;
    end
    data_d.side.sv    = start_value_i;
    data_d.side.ev    = end_value_i;
    data_d.side.angle = is_angle_i;
    data_d.side.flag  = 1'b0;
    data_d.mode       = kci_pkg::MODE_DIV;
    data_d.rem        = num_f[kci_pkg::RW-1:0];
    data_d.den        = den_f[kci_pkg::DW-1:0];
    data_d.q          = '0;
    if (key_time_i == next_key_time_i) begin
      data_d.mode = kci_pkg::MODE_ZERO;
    end else if (num_f < 0) begin
      data_d.mode      = kci_pkg::MODE_ZERO;
      data_d.side.flag = 1'b1;
    end else if (num_f > den_f) begin
      data_d.mode      = kci_pkg::MODE_ONE;
      data_d.side.flag = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/kci_divider.sv
`timescale 1ns / 1ps
module kci_divider (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  kci_pkg::div_t   data_i,
  output logic            valid_o,
  output kci_pkg::prog_t  data_o
);

  localparam int NS = kci_pkg::FRAC_BITS + 1;

  kci_pkg::div_t stg_q [NS];
  kci_pkg::div_t stg_d [NS];
  logic          vld_q [NS];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    kci_pkg::div_t src;
    logic          src_v;
    logic [kci_pkg::RW-1:0] shifted;
    logic          ge;

    if (j == 0) begin : g_first
      assign src     = data_i;
      assign src_v   = valid_i;
      assign shifted = data_i.rem;
    end else begin : g_next
      assign src     = stg_q[j-1];
      assign src_v   = vld_q[j-1];
      assign shifted = {stg_q[j-1].rem[kci_pkg::RW-2:0], 1'b0};
    end

    always_comb begin
      ge = shifted >= {1'b0, src.den};
      stg_d[j]     = src;
      stg_d[j].rem = ge ? shifted - {1'b0, src.den} : shifted;
      stg_d[j].q   = {src.q[kci_pkg::TW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[j] <= stg_d[j];
      end
    end
  end

  always_comb begin
    data_o.side = stg_q[NS-1].side;
    case (stg_q[NS-1].mode)
      kci_pkg::MODE_ONE:  data_o.t = kci_pkg::T_ONE;
      kci_pkg::MODE_ZERO: data_o.t = '0;
      default:            data_o.t = stg_q[NS-1].q;
    endcase
  end

  assign valid_o = vld_q[NS-1];

endmodule

>>> rtl/kci_bezier.sv
`timescale 1ns / 1ps
module kci_bezier (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  kci_pkg::prog_t         data_i,
  input  logic [2:0]             curve_type_i,
  input  logic [3:0][17:0]       ctrl_i,
  output logic                   valid_o,
  output kci_pkg::bez_t          data_o
);

  localparam int NL = kci_pkg::NLVL;

  kci_pkg::bez_t init;
  kci_pkg::bez_t stg_q [NL];
  kci_pkg::bez_t stg_d [NL];
  logic          vld_q [NL];
  logic [2:0]    deg;

  always_comb begin
    deg = ((curve_type_i >= kci_pkg::CURVE_QUADRATIC) &&
           (curve_type_i <= kci_pkg::CURVE_QUINTIC)) ? curve_type_i : 3'd0;
    init.side = data_i.side;
    init.t    = data_i.t;
    init.p    = '0;
    for (int i = 1; i < kci_pkg::NPTS; i++) begin
      if (i < int'(deg)) begin
        init.p[i] = kci_pkg::ctrl_fix($signed(ctrl_i[i-1]));
      end else if (i == int'(deg)) begin
        init.p[i] = kci_pkg::EW'(kci_pkg::T_ONE);
      end
    end
  end

  for (genvar k = 0; k < NL; k++) begin : g_level
    localparam int LVL = NL - k;
    kci_pkg::bez_t src;
    logic          src_v;

    if (k == 0) begin : g_first
      assign src   = init;
      assign src_v = valid_i;
    end else begin : g_next
      assign src   = stg_q[k-1];
      assign src_v = vld_q[k-1];
    end

    always_comb begin
      stg_d[k] = src;
      if (LVL <= int'(deg)) begin
        for (int i = 0; i < LVL; i++) begin
          stg_d[k].p[i] = kci_pkg::bez_lerp($signed(src.p[i]), $signed(src.p[i+1]), src.t);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  assign valid_o = vld_q[NL-1];
  assign data_o  = stg_q[NL-1];

endmodule

>>> rtl/kci_lerp.sv
`timescale 1ns / 1ps
module kci_lerp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  kci_pkg::bez_t       data_i,
  input  logic [2:0]          curve_type_i,
  input  logic [1:0]          spin_i,
  output logic                valid_o,
  output logic signed [31:0]  value_o,
  output logic                flag_o
);

  localparam logic signed [kci_pkg::PW-1:0] MAXV = kci_pkg::PW'(64'sd2147483647);
  localparam logic signed [kci_pkg::PW-1:0] MINV = -kci_pkg::PW'(64'sd2147483648);

  logic signed [kci_pkg::VW-1:0] sv_w, ev_w, dif;
  logic signed [kci_pkg::EW-1:0] e;

  logic signed [kci_pkg::VW-1:0] dif_q, dif_d;
  logic signed [kci_pkg::EW-1:0] e_q, e_d;
  logic signed [31:0]            sva_q, svb_q;
  logic                          fla_q, flb_q, va_q, vb_q, vc_q;
  logic signed [kci_pkg::PW-1:0] prod_q, prod_d, rsum;
  logic signed [31:0]            res_q, res_d;
  logic                          flc_q;

  always_comb begin
    sv_w = kci_pkg::VW'(data_i.side.sv);
    ev_w = kci_pkg::VW'(data_i.side.ev);
    if (curve_type_i == kci_pkg::CURVE_LINEAR) begin
      e = $signed({2'b00, data_i.t});
    end else if ((curve_type_i >= kci_pkg::CURVE_QUADRATIC) &&
                 (curve_type_i <= kci_pkg::CURVE_QUINTIC)) begin
      e = $signed(data_i.p[0]);
    end else begin
      e = '0;
    end
    dif = ev_w - sv_w;
    if (data_i.side.angle) begin
      if (spin_i == 2'b00) begin
        e = '0;
      end else if (spin_i[1]) begin
        if (dif > 0) ev_w = ev_w - kci_pkg::ANGLE_TURN;
      end else begin
        if (dif < 0) ev_w = ev_w + kci_pkg::ANGLE_TURN;
      end
    end
    dif_d = ev_w - sv_w;
    e_d   = e;
  end

  always_comb begin
    prod_d = kci_pkg::PW'(dif_q) * kci_pkg::PW'(e_q);
    rsum   = kci_pkg::PW'(svb_q) + (prod_q >>> kci_pkg::FRAC_BITS);
    if (rsum > MAXV) begin
      res_d = 32'sh7fffffff;
    end else if (rsum < MINV) begin
      res_d = 32'sh80000000;
    end else begin
      res_d = rsum[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dif_q  <= dif_d;
      e_q    <= e_d;
      sva_q  <= data_i.side.sv;
      fla_q  <= data_i.side.flag;
      prod_q <= prod_d;
      svb_q  <= sva_q;
      flb_q  <= fla_q;
      res_q  <= res_d;
      flc_q  <= flb_q;
    end
  end

  assign valid_o = vc_q;
  assign value_o = res_q;
  assign flag_o  = flc_q;

endmodule

>>> rtl/keyframe_curve_interpolator.sv
`timescale 1ns / 1ps
// channel  | direction | handshake              | payload
// input    | in        | in_valid_i/in_ready_o  | current_time, start_value, end_value, is_angle
// output   | out       | out_valid_o/out_ready_i| interpolated_value, t_clamped
// config   | in        | cfg_we_i               | cfg_index_i, cfg_data_i
//
// One transaction per cycle while the output is not stalled; the pipeline is a front stage,
// one divider stage per quotient bit, five Bezier level stages and three lerp stages.
// Reset clears all valid bits and sets the registers to linear curve, spin 1, keys 0, control points 0.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
module keyframe_curve_interpolator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [23:0]         current_time_i,
  input  logic signed [31:0]  start_value_i,
  input  logic signed [31:0]  end_value_i,
  input  logic                is_angle_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  interpolated_value_o,
  output logic                t_clamped_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [17:0]         cfg_data_i
);

  logic [2:0]       curve_q;
  logic [1:0]       spin_q;
  logic [15:0]      key_q, next_q;
  logic [3:0][17:0] ctrl_q;
  logic             en;

  logic             fr_v, dv_v, bz_v;
  kci_pkg::div_t    fr_d;
  kci_pkg::prog_t   dv_d;
  kci_pkg::bez_t    bz_d;

  assign en         = out_ready_i | ~out_valid_o;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_q <= kci_pkg::CURVE_LINEAR;
      spin_q  <= 2'b01;
      key_q   <= '0;
      next_q  <= '0;
      ctrl_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        kci_pkg::REG_CURVE:    curve_q   <= cfg_data_i[2:0];
        kci_pkg::REG_SPIN:     spin_q    <= cfg_data_i[1:0];
        kci_pkg::REG_KEY:      key_q     <= cfg_data_i[15:0];
        kci_pkg::REG_NEXT_KEY: next_q    <= cfg_data_i[15:0];
        kci_pkg::REG_CTRL1:    ctrl_q[0] <= cfg_data_i;
        kci_pkg::REG_CTRL2:    ctrl_q[1] <= cfg_data_i;
        kci_pkg::REG_CTRL3:    ctrl_q[2] <= cfg_data_i;
        kci_pkg::REG_CTRL4:    ctrl_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  kci_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .current_time_i, .start_value_i, .end_value_i, .is_angle_i,
    .key_time_i(key_q), .next_key_time_i(next_q),
    .valid_o(fr_v), .data_o(fr_d)
  );

  kci_divider u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(fr_v), .data_i(fr_d),
    .valid_o(dv_v), .data_o(dv_d)
  );

  kci_bezier u_bez (
    .clk_i, .rst_ni, .en_i(en), .valid_i(dv_v), .data_i(dv_d),
    .curve_type_i(curve_q), .ctrl_i(ctrl_q),
    .valid_o(bz_v), .data_o(bz_d)
  );

  kci_lerp u_lerp (
    .clk_i, .rst_ni, .en_i(en), .valid_i(bz_v), .data_i(bz_d),
    .curve_type_i(curve_q), .spin_i(spin_q),
    .valid_o(out_valid_o), .value_o(interpolated_value_o), .flag_o(t_clamped_o)
  );

  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v |-> (dv_d.t <= kci_pkg::T_ONE))
    else $error("progress above one");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(fr_v) && $stable(dv_v) && $stable(bz_v)))
    else $error("pipeline moved during stall");

  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(en))
    else $error("result appeared without advance");

endmodule

>>> test/keyframe_curve_interpolator_tb.sv
`timescale 1ns / 1ps
module keyframe_curve_interpolator_tb;
  import kci_pkg::*;

  typedef struct packed {
    logic [23:0]        now;
    logic signed [31:0] start_v;
    logic signed [31:0] end_v;
    logic               angle;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               clamped;
  } curve_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [23:0] current_time_i = '0;
  logic signed [31:0] start_value_i = '0;
  logic signed [31:0] end_value_i = '0;
  logic is_angle_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] interpolated_value_o;
  logic t_clamped_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [17:0] cfg_data_i = '0;

  keyframe_curve_interpolator dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [2:0]         m_curve;
  logic [1:0]         m_spin;
  logic [15:0]        m_key, m_next;
  logic signed [17:0] m_ctrl [4];

  sample_t    pending_q [$];
  curve_out_t expected_q [$];
  int  mismatches = 0;
  int  received = 0;
  bit  calm = 0;
  bit  stim_done = 0;

  function automatic longint floor_shift(longint v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic longint eased(longint t);
    longint p [6];
    int n;
    if (m_curve == CURVE_LINEAR) return t;
    if (m_curve < CURVE_QUADRATIC || m_curve > CURVE_QUINTIC) return 0;
    n = int'(m_curve) + 1;
    p[0] = 0;
    for (int i = 1; i + 1 < n; i++) p[i] = longint'(m_ctrl[i-1]) <<< CUP >>> CDN;
    p[n-1] = longint'(1) <<< FRAC_BITS;
    for (int l = n - 1; l > 0; l--)
      for (int i = 0; i < l; i++) p[i] = p[i] + floor_shift((p[i+1] - p[i]) * t);
    return p[0];
  endfunction

  function automatic curve_out_t interpolate(sample_t s);
    curve_out_t o;
    longint num, den, t, e, sv, ev, r, spin;
    sv = s.start_v;
    ev = s.end_v;
    spin = longint'($signed(m_spin));
    o.clamped = 1'b0;
    e = 0;
    if (m_key != m_next) begin
      num = longint'(s.now) - (longint'(m_key) <<< 8);
      den = (longint'(m_next) - longint'(m_key)) * 256;
      if (den < 0) begin
        num = -num;
        den = -den;
      end
      if (num < 0) begin
        t = 0;
        o.clamped = 1'b1;
      end else if (num > den) begin
        t = longint'(1) <<< FRAC_BITS;
        o.clamped = 1'b1;
      end else begin
        t = (num <<< FRAC_BITS) / den;
      end
      e = eased(t);
    end
    if (s.angle) begin
      if (spin == 0) e = 0;
      else if (spin > 0) begin
        if (ev - sv < 0) ev += 360 * 65536;
      end else if (ev - sv > 0) ev -= 360 * 65536;
    end
    r = sv + floor_shift((ev - sv) * e);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    o.value = r[31:0];
    return o;
  endfunction

  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      expected_q.push_back(interpolate({current_time_i, start_value_i, end_value_i,
                                        is_angle_i}));
      void'(pending_q.pop_front());
    end
    if (!(in_valid_i && !in_ready_o)) begin
      if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 36)) begin
        sample_t s;
        s = pending_q[0];
        in_valid_i <= 1'b1;
        current_time_i <= s.now;
        start_value_i <= s.start_v;
        end_value_i <= s.end_v;
        is_angle_i <= s.angle;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      received++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", interpolated_value_o);
      end else begin
        curve_out_t x;
        x = expected_q.pop_front();
        if (x.value !== interpolated_value_o || x.clamped !== t_clamped_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %0d clamp %0b, got %0d clamp %0b",
                     x.value, x.clamped, interpolated_value_o, t_clamped_o);
        end
      end
    end
    out_ready_i <= calm || ($urandom_range(99) >= 36);
  end

  task automatic write_reg(logic [2:0] idx, logic [17:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_CURVE:    m_curve <= data[2:0];
      REG_SPIN:     m_spin <= data[1:0];
      REG_KEY:      m_key <= data[15:0];
      REG_NEXT_KEY: m_next <= data[15:0];
      default:      m_ctrl[idx - REG_CTRL1] <= data;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !in_valid_i);
    wait (expected_q.size() == 0);
    repeat (FRAC_BITS + 20) @(posedge clk_i);
  endtask

  function automatic sample_t random_sample(logic [15:0] k0, logic [15:0] k1);
    sample_t s;
    int lo, hi;
    lo = int'(k0 < k1 ? k0 : k1);
    hi = int'(k0 < k1 ? k1 : k0);
    s.now = 24'($urandom);
    if ($urandom_range(3) != 0)
      s.now = 24'($urandom_range(hi * 256 + 300, lo > 1 ? lo * 256 - 300 : 0));
    s.start_v = 32'($urandom);
    s.end_v = 32'($urandom);
    if ($urandom_range(1)) begin
      s.start_v = 32'($signed($urandom_range(720 * 65536)) - 360 * 65536);
      s.end_v = 32'($signed($urandom_range(720 * 65536)) - 360 * 65536);
    end
    s.angle = 1'($urandom);
    return s;
  endfunction

  task automatic set_keys(logic [15:0] k0, logic [15:0] k1);
    write_reg(REG_KEY, {2'b0, k0});
    write_reg(REG_NEXT_KEY, {2'b0, k1});
  endtask

  initial begin
    m_curve = CURVE_LINEAR;
    m_spin = 2'sd1;
    m_key = '0;
    m_next = '0;
    for (int i = 0; i < 4; i++) m_ctrl[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    pending_q.push_back({24'd100, 32'sh7fffffff, 32'sh80000000, 1'b0});
    drain();
    set_keys(16'd10, 16'd20);
    pending_q.push_back({24'd0, 32'sh10000, 32'sh20000, 1'b0});
    pending_q.push_back({24'hffffff, 32'sh80000000, 32'sh7fffffff, 1'b0});
    pending_q.push_back({24'd3840, 32'sh7fffffff, 32'sh80000000, 1'b1});
    pending_q.push_back({24'd2560, 32'sh0, 32'sh10000, 1'b0});
    pending_q.push_back({24'd5120, 32'sh0, 32'sh10000, 1'b0});
    drain();
    set_keys(16'd20, 16'd10);
    pending_q.push_back({24'd3840, 32'sh0, 32'sh640000, 1'b0});
    pending_q.push_back({24'd1000, 32'sh0, 32'sh640000, 1'b0});
    drain();
    for (int c = 0; c < 8; c++) begin
      write_reg(REG_CURVE, 18'(c));
      for (int k = 0; k < 4; k++)
        write_reg(3'(REG_CTRL1 + k), (c & 1) ? 18'h1ffff : 18'h20000);
      pending_q.push_back({24'd3000, 32'sh7fffffff, 32'sh80000000, 1'b0});
      pending_q.push_back({24'd4000, 32'sh1000000, 32'sh20000, 1'b1});
      drain();
    end
    for (int sp = 0; sp < 4; sp++) begin
      write_reg(REG_SPIN, 18'(sp));
      pending_q.push_back({24'd3500, 32'sh1000000, 32'sh20000, 1'b1});
      pending_q.push_back({24'd3500, 32'sh20000, 32'sh1000000, 1'b1});
      drain();
    end

    for (int ph = 0; ph < 12; ph++) begin
      logic [15:0] k0, k1;
      calm = (ph == 5);
      k0 = (ph == 0) ? 16'd0 : (ph == 1) ? 16'hffff : 16'($urandom_range(200));
      k1 = (ph == 0) ? 16'hffff : (ph == 1) ? 16'd0 :
           16'(k0 + $urandom_range(100) - 20);
      if (ph == 7) k1 = k0;
      set_keys(k0, k1);
      write_reg(REG_CURVE, (ph < 9) ? 18'($urandom_range(5)) : 18'($urandom_range(7)));
      write_reg(REG_SPIN, 18'($urandom_range(3)));
      for (int k = 0; k < 4; k++) write_reg(3'(REG_CTRL1 + k), 18'($urandom));
      repeat (52) pending_q.push_back(random_sample(k0, k1));
      drain();
    end
    calm = 0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
